/* hw/rtl/assert_macros.svh */
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a clock and an active-low reset.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ggc_pkg.sv */
// ------------------------------------------------------------------------
// ggc_pkg
// Types and constants shared by the greedy graph coloring block.
// ------------------------------------------------------------------------
package ggc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MASK_W           = 64;
    localparam int IDX_W            = 6;
    localparam int COLOR_W          = 6;
    localparam int CHUNK_W          = 8;
    localparam int CHUNK_SEL_W      = 3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIND,
        ST_EMIT
    } t_ggc_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the input word, start a new vertex
        logic scan_step;  // read one stored color, advance neighbor index
        logic find_step;  // test one chunk of the used-color bitmap
        logic commit;     // store the color, load the result word
    } t_ggc_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic first_vtx;  // next vertex has index zero: nothing to scan
        logic scan_last;  // current neighbor index is the last earlier one
        logic found;      // current chunk holds a free color
        logic out_free;   // result register can take a word this cycle
    } t_ggc_sts;

endpackage

/* hw/rtl/greedy_graph_coloring.sv */
// ------------------------------------------------------------------------
// greedy_graph_coloring
// First-fit greedy coloring of a graph presented one vertex per word.
// ------------------------------------------------------------------------
// Each input word carries the neighbor mask of the next vertex in index
// order; the block answers with one word holding the vertex index, the
// smallest color not used by its lower-index neighbors, and the
// last-vertex flag. After its word is accepted, the block steps through
// each earlier vertex index to read its color from the color memory,
// drains the read, searches for the first free color (eight bitmap bits
// per cycle), and commits the result. The commit waits while the previous
// result is still held. The next word is taken in the cycle after the
// commit, so a new word is not taken before the last vertex is committed.
// One vertex is worked on at a time; the result register lets the next
// word be accepted while a result waits to be taken.
// Numbering restarts at zero after the last-vertex flag or after
// MAX_VERTICES vertices.
module greedy_graph_coloring #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ggc_pkg::MASK_W-1:0]   i_neighbor_mask,
    input  logic                         i_last_vertex,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ggc_pkg::IDX_W-1:0]    o_vertex_index,
    output logic [ggc_pkg::COLOR_W-1:0]  o_vertex_color,
    output logic                         o_graph_done
);

    ggc_pkg::t_ggc_cmd cmd;
    ggc_pkg::t_ggc_sts sts;

    ggc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ggc_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_neighbor_mask (i_neighbor_mask),
        .i_last_vertex   (i_last_vertex),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_vertex_index  (o_vertex_index),
        .o_vertex_color  (o_vertex_color),
        .o_graph_done    (o_graph_done)
    );

endmodule

/* hw/rtl/ggc_ctrl.sv */
// ------------------------------------------------------------------------
// ggc_ctrl
// Sequencer for one vertex: accept, scan earlier neighbors, drain the
// read pipe, search for the first free color, commit the result.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module ggc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ggc_pkg::t_ggc_sts i_sts,
    output ggc_pkg::t_ggc_cmd o_cmd
);

    ggc_pkg::t_ggc_state r_state;
    ggc_pkg::t_ggc_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ggc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ggc_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.first_vtx ? ggc_pkg::ST_DRAIN : ggc_pkg::ST_SCAN;
                end
            end
            ggc_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ggc_pkg::ST_DRAIN;
                end
            end
            ggc_pkg::ST_DRAIN: begin
                n_state = ggc_pkg::ST_FIND;
            end
            ggc_pkg::ST_FIND: begin
                o_cmd.find_step = 1'b1;
                if (i_sts.found) begin
                    n_state = ggc_pkg::ST_EMIT;
                end
            end
            ggc_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ggc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ggc_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_one_cmd, i_clk, i_rst_n, $onehot0(o_cmd), "more than one command at once")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "accepted twice in a row")
    `ASSERT_IMPLIES(a_commit_free, i_clk, i_rst_n, o_cmd.commit, i_sts.out_free, "commit over a full result")

endmodule

/* hw/rtl/ggc_dp.sv */
// ------------------------------------------------------------------------
// ggc_dp
// Datapath: vertex counter, color memory, used-color bitmap, chunked
// first-free search and the result register.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module ggc_dp #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ggc_pkg::t_ggc_cmd            i_cmd,
    output ggc_pkg::t_ggc_sts            o_sts,
    input  logic [ggc_pkg::MASK_W-1:0]   i_neighbor_mask,
    input  logic                         i_last_vertex,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ggc_pkg::IDX_W-1:0]    o_vertex_index,
    output logic [ggc_pkg::COLOR_W-1:0]  o_vertex_color,
    output logic                         o_graph_done
);

    localparam int VW = $clog2(MAX_VERTICES);

    logic [ggc_pkg::COLOR_W-1:0] mem [MAX_VERTICES];

    logic [ggc_pkg::MASK_W-1:0]      r_mask;
    logic                            r_last;
    logic [VW-1:0]                   r_vtx;
    logic [VW-1:0]                   r_cur;
    logic [VW-1:0]                   r_u;
    logic                            r_rd_tag;
    logic [ggc_pkg::COLOR_W-1:0]     r_rd_data;
    logic [ggc_pkg::MASK_W-1:0]      r_used;
    logic [ggc_pkg::CHUNK_SEL_W-1:0] r_chunk;
    logic [ggc_pkg::COLOR_W-1:0]     r_color;
    logic                            r_out_valid;
    logic [ggc_pkg::IDX_W-1:0]       r_out_index;
    logic [ggc_pkg::COLOR_W-1:0]     r_out_color;
    logic                            r_out_done;

    logic [ggc_pkg::MASK_W-1:0]      used_cap;
    logic [ggc_pkg::CHUNK_W-1:0]     chunk;
    logic [ggc_pkg::CHUNK_SEL_W-1:0] chunk_ffz;
    logic [ggc_pkg::IDX_W-1:0]       u_ext;

    // First zero bit in an eight-bit chunk
    function automatic logic [ggc_pkg::CHUNK_SEL_W-1:0] ffz8(
        input logic [ggc_pkg::CHUNK_W-1:0] b
    );
        logic [ggc_pkg::CHUNK_SEL_W-1:0] r;
        r = '0;
        for (int i = ggc_pkg::CHUNK_W - 1; i >= 0; i--) begin
            if (!b[i]) begin
                r = ggc_pkg::CHUNK_SEL_W'(i);
            end
        end
        return r;
    endfunction

    // Top color is always available as a fallback
    assign used_cap  = {1'b0, r_used[ggc_pkg::MASK_W-2:0]};
    assign chunk     = used_cap[{r_chunk, 3'b000} +: ggc_pkg::CHUNK_W];
    assign chunk_ffz = ffz8(chunk);
    assign u_ext     = ggc_pkg::IDX_W'(r_u);

    // Status toward the controller
    assign o_sts.first_vtx = (r_vtx == '0);
    assign o_sts.scan_last = (r_u == r_cur - VW'(1));
    assign o_sts.found     = ~&chunk;
    assign o_sts.out_free  = !r_out_valid || i_ready;

    // Color memory: write on commit, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem[r_cur] <= r_color;
        end
        r_rd_data <= mem[r_u];
    end

    // Capture the input word and run the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mask  <= i_neighbor_mask;
            r_last  <= i_last_vertex;
            r_cur   <= r_vtx;
            r_u     <= '0;
            r_chunk <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_u <= r_u + VW'(1);
            end
            if (i_cmd.find_step && !o_sts.found) begin
                r_chunk <= r_chunk + ggc_pkg::CHUNK_SEL_W'(1);
            end
        end
        if (i_cmd.find_step && o_sts.found) begin
            r_color <= {r_chunk, chunk_ffz};
        end
    end

    // Gather colors of earlier neighbors
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_used <= '0;
        end else if (r_rd_tag) begin
            r_used <= r_used | (ggc_pkg::MASK_W'(1) << r_rd_data);
        end
    end

    // Read tag and vertex counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= 1'b0;
            r_vtx    <= '0;
        end else begin
            r_rd_tag <= i_cmd.scan_step && r_mask[u_ext];
            if (i_cmd.commit) begin
                if (r_last || (r_cur == VW'(MAX_VERTICES - 1))) begin
                    r_vtx <= '0;
                end else begin
                    r_vtx <= r_cur + VW'(1);
                end
            end
        end
    end

    // Result register: hold the word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_index <= ggc_pkg::IDX_W'(r_cur);
            r_out_color <= r_color;
            r_out_done  <= r_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_vertex_index = r_out_index;
    assign o_vertex_color = r_out_color;
    assign o_graph_done   = r_out_done;

    `ASSERT_IMPLIES(a_scan_bound, i_clk, i_rst_n, i_cmd.scan_step, r_u < r_cur, "scan past vertex")
    `ASSERT_IMPLIES(a_color_bound, i_clk, i_rst_n, i_cmd.commit, r_color <= ggc_pkg::COLOR_W'(r_cur), "color above neighbor count")
    `ASSERT_NEXT(a_vtx_step, i_clk, i_rst_n, i_cmd.commit && !r_last && (r_cur != VW'(MAX_VERTICES - 1)), r_vtx == $past(r_cur) + VW'(1), "vertex counter skipped")

endmodule

/* sim/testbench.sv */
// ------------------------------------------------------------------------
// testbench
// Self-checking bench for greedy_graph_coloring: a clocked driver sends
// vertex words from a pending queue, a clocked monitor predicts the
// first-fit color of each accepted vertex and checks every result word.
// Traffic runs through several idling phases, a long receiver hold-off
// that backs up the block, and drained pauses between phases.
// ------------------------------------------------------------------------
module testbench;

    localparam int NUM_VERTICES = ggc_pkg::MAX_VERTICES_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 80;

    typedef struct packed {
        logic [ggc_pkg::MASK_W-1:0] mask;
        logic                       last;
    } t_vertex_word;

    typedef struct packed {
        logic [ggc_pkg::IDX_W-1:0]   index;
        logic [ggc_pkg::COLOR_W-1:0] color;
        logic                        done;
    } t_coloring;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [ggc_pkg::MASK_W-1:0]   i_neighbor_mask = '0;
    logic                         i_last_vertex = 1'b0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [ggc_pkg::IDX_W-1:0]    o_vertex_index;
    logic [ggc_pkg::COLOR_W-1:0]  o_vertex_color;
    logic                         o_graph_done;

    t_vertex_word        vertex_words[$];
    t_coloring           expected_colorings[$];

    // Predictor state: colors of the current pass and the next vertex index
    logic [ggc_pkg::COLOR_W-1:0] color_mem [0:NUM_VERTICES-1];
    logic [ggc_pkg::IDX_W-1:0]   vertex_cnt = '0;

    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    bit                  rx_hold = 1'b0;
    bit                  hold_go = 1'b0;
    bit                  word_taken = 1'b0;
    int                  errors = 0;

    greedy_graph_coloring dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_neighbor_mask (i_neighbor_mask),
        .i_last_vertex   (i_last_vertex),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_vertex_index  (o_vertex_index),
        .o_vertex_color  (o_vertex_color),
        .o_graph_done    (o_graph_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Color one vertex first-fit against its lower-index neighbors
    function automatic t_coloring color_next_vertex(t_vertex_word w);
        logic [63:0] used;
        int          v;
        int          pick;
        t_coloring   c;
        used = '0;
        v    = int'(vertex_cnt);
        for (int u = 0; u < v; u++) begin
            if (w.mask[u]) used[color_mem[u]] = 1'b1;
        end
        pick = 0;
        while (pick < 63 && used[pick]) pick++;
        color_mem[v] = ggc_pkg::COLOR_W'(pick);
        vertex_cnt   = (w.last || v + 1 >= NUM_VERTICES) ? '0 : ggc_pkg::IDX_W'(v + 1);
        c.index = ggc_pkg::IDX_W'(v);
        c.color = ggc_pkg::COLOR_W'(pick);
        c.done  = w.last;
        return c;
    endfunction

    // Queue one graph; density sets the chance of each earlier-neighbor bit
    task automatic queue_graph(input int n_vertices, input int density,
                               input bit close_graph);
        t_vertex_word w;
        int           pos;
        for (int k = 0; k < n_vertices; k++) begin
            pos    = k % NUM_VERTICES;
            w.mask = {$urandom, $urandom};
            for (int u = 0; u < pos; u++) w.mask[u] = ($urandom_range(99) < density);
            w.last = close_graph && (k == n_vertices - 1);
            vertex_words.insert(vertex_words.size(), w);
        end
    endtask

    // Queue random graphs, mostly small, some up to full size and some overlong
    task automatic queue_random_graphs(input int n_words);
        int count;
        int sel;
        int n;
        count = 0;
        while (count < n_words) begin
            sel = $urandom_range(99);
            if (sel < 78) n = $urandom_range(1, 12);
            else if (sel < 95) n = $urandom_range(13, NUM_VERTICES);
            else n = $urandom_range(NUM_VERTICES + 1, NUM_VERTICES + 26);
            queue_graph(n, $urandom_range(0, 100), (n != NUM_VERTICES) || $urandom_range(1));
            count += n;
        end
    endtask

    // Hold until every queued word went in and every result came back
    task automatic drain();
        while (vertex_words.size() != 0 || i_valid || expected_colorings.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_word(input logic [ggc_pkg::MASK_W-1:0] mask, input logic last);
        t_vertex_word w;
        w.mask = mask;
        w.last = last;
        vertex_words.insert(vertex_words.size(), w);
    endtask

    // Drive input words at the falling edge; hold each until taken
    always @(negedge i_clk) begin
        if (!i_valid || word_taken) begin
            if (vertex_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                t_vertex_word w;
                w = vertex_words.pop_front();
                i_valid         <= 1'b1;
                i_neighbor_mask <= w.mask;
                i_last_vertex   <= w.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, or fully during a hold-off
    always @(negedge i_clk) begin
        i_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Check result words and predict each accepted input word
    always @(posedge i_clk) begin
        t_coloring    exp;
        t_vertex_word w;
        word_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_colorings.size() == 0) begin
                    $display("%0t: unexpected result word: index %0d color %0d done %0d",
                             $time, o_vertex_index, o_vertex_color, o_graph_done);
                    errors++;
                end else begin
                    exp = expected_colorings.pop_front();
                    if (o_vertex_index !== exp.index) begin
                        $display("%0t: vertex_index mismatch: expected %0d, actual %0d",
                                 $time, exp.index, o_vertex_index);
                        errors++;
                    end
                    if (o_vertex_color !== exp.color) begin
                        $display("%0t: vertex_color mismatch: expected %0d, actual %0d",
                                 $time, exp.color, o_vertex_color);
                        errors++;
                    end
                    if (o_graph_done !== exp.done) begin
                        $display("%0t: graph_done mismatch: expected %0d, actual %0d",
                                 $time, exp.done, o_graph_done);
                        errors++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                w.mask = i_neighbor_mask;
                w.last = i_last_vertex;
                expected_colorings.insert(expected_colorings.size(), color_next_vertex(w));
            end
        end
    end

    // Long receiver hold-off so the block backs up and drops its ready
    initial begin
        while (!hold_go) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_VERTICES; i++) color_mem[i] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: self bit only, lower-neighbor chains, higher bits only
        push_word('1, 1'b1);
        push_word('0, 1'b0);
        push_word('1, 1'b0);
        push_word('1, 1'b0);
        push_word(64'h0000_0000_0000_0001, 1'b0);
        push_word('0, 1'b0);
        push_word(64'hFFFF_FFFF_FFFF_FFE0, 1'b1);
        push_word('0, 1'b1);
        push_word('0, 1'b1);
        push_word(64'h8000_0000_0000_0000, 1'b0);
        push_word(64'h0000_0000_0000_0002, 1'b1);
        push_word(64'h5555_5555_5555_5555, 1'b0);
        push_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        push_word(64'h0000_0000_0000_0003, 1'b1);
        drain();

        // Phase: no idling, complete graph up to the top color, hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go     = 1'b1;
        queue_graph(NUM_VERTICES, 100, 1'b1);
        queue_graph(NUM_VERTICES + 8, 100, 1'b1);
        queue_random_graphs(180);
        drain();

        // Phase: sender idles
        tx_idle_pct = 47;
        rx_idle_pct = 0;
        queue_random_graphs(310);
        drain();

        // Phase: receiver stalls
        tx_idle_pct = 0;
        rx_idle_pct = 47;
        queue_random_graphs(310);
        drain();

        // Phase: both sides idle
        tx_idle_pct = 17;
        rx_idle_pct = 17;
        queue_random_graphs(310);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
